// File: hdl/fpar_pkg.sv
package fpar_pkg;

    // Field and register widths
    localparam int SMP_W   = 16;
    localparam int PEAK_W  = 16;
    localparam int RATE_W  = 18;
    localparam int TRIM_W  = 14;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W = 2;
    // Phase plus source rate needs one bit more than a rate
    localparam int DVD_W   = RATE_W + 1;

    // Defaults and limits
    localparam int FIFO_DEPTH_DEF = 8192;
    localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(8000);
    localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(192000);
    localparam logic [TRIM_W-1:0] TRIM_RESET = TRIM_W'(4 * 1024);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_RATE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_LEVEL  = 2'd2;

    // Operation codes carried in tuser
    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_PULL  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_TRIM  = 2'd3
    } t_op;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic div_start;
        logic clamp;
        logic read;
        logic load;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic pull_ok;
        logic div_done;
        logic quo_zero;
        logic out_free;
    } t_sts;

endpackage

// File: hdl/fpar_div.sv
module fpar_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [fpar_pkg::DVD_W-1:0]        i_dividend,
    input  logic [fpar_pkg::RATE_W-1:0]       i_divisor,
    output logic                              o_done,
    output logic [fpar_pkg::DVD_W-1:0]        o_quotient,
    output logic [fpar_pkg::RATE_W-1:0]       o_remainder
);

    localparam int DW  = fpar_pkg::DVD_W;
    localparam int RW  = fpar_pkg::RATE_W;
    localparam int CW  = $clog2(DW + 1);

    logic [RW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [RW:0]   shifted;
    logic [RW:0]   trial;
    logic          bit_ok;

    // One restoring step: shift in next dividend bit, try subtract
    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        trial   = shifted - {1'b0, i_divisor};
        bit_ok  = ~trial[RW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= bit_ok ? trial[RW-1:0] : shifted[RW-1:0];
            r_quo <= {r_quo[DW-2:0], bit_ok};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// File: hdl/fpar_dp.sv
module fpar_dp #(
    parameter int FIFO_DEPTH = fpar_pkg::FIFO_DEPTH_DEF,
    parameter int CNT_W      = $clog2(FIFO_DEPTH + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input transfer payload
    input  logic [fpar_pkg::OP_W-1:0]           i_op,
    input  logic [fpar_pkg::SMP_W-1:0]          i_sample,
    // Configuration writes
    input  logic                                i_cfg_we,
    input  logic [fpar_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpar_pkg::RATE_W-1:0]         i_cfg_data,
    // Output side
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [fpar_pkg::SMP_W-1:0]          o_sample,
    output logic                                o_available,
    output logic                                o_dropped,
    output logic [CNT_W-1:0]                    o_count,
    output logic [fpar_pkg::PEAK_W-1:0]         o_peak,
    // Control
    input  fpar_pkg::t_cmd                      i_cmd,
    output fpar_pkg::t_sts                      o_sts
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int SW    = fpar_pkg::SMP_W;
    localparam int RW    = fpar_pkg::RATE_W;
    localparam int TRW   = fpar_pkg::TRIM_W;
    localparam int DW    = fpar_pkg::DVD_W;
    localparam int TW    = (CNT_W > TRW) ? CNT_W : TRW;
    localparam int QW    = (CNT_W > DW) ? CNT_W : DW;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    // Sample memory
    logic [SW-1:0]     r_mem [FIFO_DEPTH];
    logic [SW-1:0]     r_rdata;

    // FIFO and converter state
    logic [PTR_W-1:0]  r_rp;
    logic [PTR_W-1:0]  r_wp;
    logic [CNT_W-1:0]  r_cnt;
    logic [RW-1:0]     r_phase;
    logic [SW-1:0]     r_held;
    logic [fpar_pkg::PEAK_W-1:0] r_peak;

    // Configuration registers
    logic [RW-1:0]     r_src;
    logic [RW-1:0]     r_tgt;
    logic [TRW-1:0]    r_trim;

    // Captured item and result in progress
    fpar_pkg::t_op     r_op;
    logic [SW-1:0]     r_sin;
    logic [SW-1:0]     r_res_sout;
    logic              r_res_avail;
    logic              r_res_drop;
    logic [CNT_W-1:0]  r_adv;

    // Output register
    logic              r_out_valid;
    logic [SW-1:0]     r_out_sout;
    logic              r_out_avail;
    logic              r_out_drop;
    logic [CNT_W-1:0]  r_out_cnt;
    logic [fpar_pkg::PEAK_W-1:0] r_out_peak;

    // Divider
    logic [DW-1:0]     div_dividend;
    logic              div_done;
    logic [DW-1:0]     div_quo;
    logic [RW-1:0]     div_rem;

    // Combinational helpers
    logic [PTR_W-1:0]  wp_inc;
    logic [PTR_W-1:0]  rp_inc;
    logic              full;
    logic [TW:0]       trim_diff;
    logic [TW:0]       trim_wrap;
    logic              trim_cut;
    logic [QW-1:0]     quo_ext;
    logic [CNT_W-1:0]  adv_clamped;
    logic [CNT_W:0]    rp_sum;
    logic [CNT_W:0]    rp_wrap;
    logic [PTR_W-1:0]  rp_new;
    logic [PTR_W-1:0]  last_addr;
    logic [fpar_pkg::PEAK_W-1:0] res_mag;
    logic [fpar_pkg::PEAK_W-1:0] peak_next;
    logic              src_ok;

    always_comb begin
        // Pointer increments with wrap
        wp_inc = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
        rp_inc = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
        full   = (r_cnt == CNT_FULL);

        // Trim: keep newest trim_level samples
        trim_cut  = TW'(r_cnt) > TW'(r_trim);
        trim_diff = (TW+1)'(r_wp) - (TW+1)'(r_trim);
        trim_wrap = trim_diff[TW] ? trim_diff + (TW+1)'(FIFO_DEPTH) : trim_diff;

        // Limit the advance to the samples held
        quo_ext     = QW'(div_quo);
        adv_clamped = (quo_ext > QW'(r_cnt)) ? r_cnt : quo_ext[CNT_W-1:0];

        // New read pointer and address of the last popped sample
        rp_sum    = (CNT_W+1)'(r_rp) + (CNT_W+1)'(r_adv);
        rp_wrap   = (rp_sum >= (CNT_W+1)'(FIFO_DEPTH)) ?
                    rp_sum - (CNT_W+1)'(FIFO_DEPTH) : rp_sum;
        rp_new    = rp_wrap[PTR_W-1:0];
        last_addr = (rp_new == '0) ? PTR_LAST : rp_new - 1'b1;

        // Peak tracking on the delivered sample
        res_mag   = r_res_sout[SW-1] ? (~r_res_sout + 1'b1) : r_res_sout;
        peak_next = (res_mag > r_peak) ? res_mag : r_peak;

        src_ok = (i_cfg_data >= fpar_pkg::RATE_MIN) &&
                 (i_cfg_data <= fpar_pkg::RATE_MAX) && (i_cfg_data != r_src);

        div_dividend = DW'(r_phase) + DW'(r_src);
    end

    fpar_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (r_tgt),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Memory write on push, registered read of the last popped entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_op == fpar_pkg::OP_PUSH)) begin
            r_mem[r_wp] <= r_sin;
        end
        if (i_cmd.read) begin
            r_rdata <= r_mem[last_addr];
        end
    end

    // FIFO, phase, peak and configuration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp    <= '0;
            r_wp    <= '0;
            r_cnt   <= '0;
            r_phase <= '0;
            r_held  <= '0;
            r_peak  <= '0;
            r_src   <= '0;
            r_tgt   <= '0;
            r_trim  <= fpar_pkg::TRIM_RESET;
        end else begin
            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fpar_pkg::CFG_SOURCE_RATE: begin
                        if (src_ok) begin
                            r_src   <= i_cfg_data;
                            r_phase <= '0;
                        end
                    end
                    fpar_pkg::CFG_TGT_RATE:    r_tgt  <= i_cfg_data;
                    fpar_pkg::CFG_TRIM_LEVEL:  r_trim <= i_cfg_data[TRW-1:0];
                    default: ;
                endcase
            end

            // Push, flush and trim, done on the exec command
            if (i_cmd.exec) begin
                case (r_op)
                    fpar_pkg::OP_PUSH: begin
                        r_wp <= wp_inc;
                        if (full) begin
                            r_rp <= rp_inc;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    fpar_pkg::OP_FLUSH: begin
                        r_rp    <= r_wp;
                        r_cnt   <= '0;
                        r_phase <= '0;
                        r_held  <= '0;
                        r_peak  <= '0;
                    end
                    fpar_pkg::OP_TRIM: begin
                        if (trim_cut) begin
                            r_cnt <= CNT_W'(r_trim);
                            r_rp  <= trim_wrap[PTR_W-1:0];
                        end
                        r_phase <= '0;
                        r_peak  <= '0;
                    end
                    default: ;
                endcase
            end

            // Pull: keep remainder, then pop
            if (i_cmd.clamp) begin
                r_phase <= div_rem;
            end
            if (i_cmd.read) begin
                r_rp  <= rp_new;
                r_cnt <= r_cnt - r_adv;
            end
            if (i_cmd.load) begin
                r_held <= r_rdata;
            end
            if (i_cmd.out_load) begin
                r_peak <= peak_next;
            end
        end
    end

    // Captured item and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= fpar_pkg::t_op'(i_op);
            r_sin       <= i_sample;
            r_res_sout  <= '0;
            r_res_avail <= 1'b0;
            r_res_drop  <= 1'b0;
        end
        if (i_cmd.exec && (r_op == fpar_pkg::OP_PUSH)) begin
            r_res_drop <= full;
        end
        if (i_cmd.clamp) begin
            r_res_avail <= 1'b1;
            r_adv       <= adv_clamped;
            if (div_quo == '0) begin
                r_res_sout <= r_held;
            end
        end
        if (i_cmd.load) begin
            r_res_sout <= r_rdata;
        end
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sout  <= r_res_sout;
            r_out_avail <= r_res_avail;
            r_out_drop  <= r_res_drop;
            r_out_cnt   <= r_cnt;
            r_out_peak  <= peak_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out_sout;
    assign o_available = r_out_avail;
    assign o_dropped   = r_out_drop;
    assign o_count     = r_out_cnt;
    assign o_peak      = r_out_peak;

    // Status to the controller
    always_comb begin
        o_sts.op       = r_op;
        o_sts.pull_ok  = (r_cnt != '0) && (r_src != '0) && (r_tgt != '0);
        o_sts.div_done = div_done;
        o_sts.quo_zero = (div_quo == '0);
        o_sts.out_free = ~r_out_valid | i_out_ready;
    end

endmodule

// File: hdl/fpar_ctrl.sv
module fpar_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fpar_pkg::t_sts  i_sts,
    output fpar_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_CLAMP,
        S_READ,
        S_LOAD,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    // Sequence one item through the datapath
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if ((i_sts.op == fpar_pkg::OP_PULL) && i_sts.pull_ok) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = i_sts.quo_zero ? S_DONE : S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Take no transfer while reset is held
    assign o_in_ready = i_rst_n && (r_state == S_IDLE);

endmodule

// File: hdl/fifo_phase_accumulator_resampler_top.sv
// Sample FIFO with phase-accumulator rate conversion. Each input transfer
// carries an operation in tuser (push, pull, flush, trim) and a signed
// 16-bit sample in tdata, and produces exactly one result transfer. Push,
// flush, trim and an unavailable pull go from acceptance through the decode
// step to the result register; an available pull runs the 19-step restoring
// divider that forms (phase + source rate) / output rate, then the clamp step,
// the registered read of the sample memory and the load step; read and load
// are skipped when the quotient is zero and the held sample repeats. One item
// is in work at a time; the next item is accepted while the previous result
// still waits in the output register. Configuration writes are taken on any
// cycle with i_cfg_we high and must only be issued while no item is in flight.
module fifo_phase_accumulator_resampler_top #(
    parameter int FIFO_DEPTH = fpar_pkg::FIFO_DEPTH_DEF,
    parameter int CNT_W      = $clog2(FIFO_DEPTH + 1),
    parameter int OUT_W      = ((2 * fpar_pkg::SMP_W + 2 + CNT_W + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [fpar_pkg::SMP_W-1:0]        s_axis_tdata,  // sample_in
    input  logic [fpar_pkg::OP_W-1:0]         s_axis_tuser,  // operation
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // sample_out, available, dropped_oldest, buffered_count, consumed_peak
    output logic [OUT_W-1:0]                  m_axis_tdata,
    // Configuration
    input  logic                              i_cfg_we,
    input  logic [fpar_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fpar_pkg::RATE_W-1:0]       i_cfg_data
);

    fpar_pkg::t_cmd cmd;
    fpar_pkg::t_sts sts;

    logic [fpar_pkg::SMP_W-1:0]  out_sample;
    logic                        out_available;
    logic                        out_dropped;
    logic [CNT_W-1:0]            out_count;
    logic [fpar_pkg::PEAK_W-1:0] out_peak;

    fpar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fpar_dp #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .CNT_W      (CNT_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (s_axis_tuser),
        .i_sample    (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_sample    (out_sample),
        .o_available (out_available),
        .o_dropped   (out_dropped),
        .o_count     (out_count),
        .o_peak      (out_peak),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    // Pack result fields from the lowest bit up, zero filled to bytes
    assign m_axis_tdata = OUT_W'({out_peak, out_count, out_dropped, out_available, out_sample});

endmodule
